/* design/lcdbi_pkg.sv */
// Shared types, codes and constants of the LCD controller bus interface.
`default_nettype none
package lcdbi_pkg;

    // Defaults for the top-level parameters.
    localparam int DISPLAY_ROWS_DEF    = 48;
    localparam int DISPLAY_COLUMNS_DEF = 64;
    localparam int STORE_DEPTH_DEF     = 512;

    // Width of the unreduced store address x * 8 + y.
    localparam int FULL_ADDR_W = 10;

    // Counter wrap points.
    localparam logic [5:0] X_LAST    = 6'd47;
    localparam logic [5:0] X_WRAP    = 6'd48;
    localparam logic [5:0] X_UNDER   = 6'h3f;
    localparam logic [3:0] Y_LAST_8  = 4'd7;
    localparam logic [3:0] Y_LAST_6  = 4'd10;
    localparam logic [3:0] Y_WRAP_8  = 4'd8;
    localparam logic [3:0] Y_WRAP_6  = 4'd11;
    localparam logic [3:0] Y_UNDER   = 4'hf;

    // Fill values of the read latch for out-of-range reads.
    localparam logic [7:0] OOR_FILL_8 = 8'hff;
    localparam logic [7:0] OOR_FILL_6 = 8'h3c;
    localparam logic [7:0] OOR_Y_TAG  = 8'h20;

    // Command byte prefixes.
    localparam logic [1:0] CMD_CONTRAST = 2'b11;
    localparam logic [1:0] CMD_X_ADDR   = 2'b10;
    localparam logic [1:0] CMD_Z_ADDR   = 2'b01;
    localparam logic [2:0] CMD_Y_ADDR   = 3'b001;
    localparam logic [4:0] CMD_TEST     = 5'b00011;
    localparam logic [4:0] CMD_OPAMP_2  = 5'b00010;
    localparam logic [4:0] CMD_OPAMP_1  = 5'b00001;
    localparam logic [5:0] CMD_COUNTER  = 6'b000001;
    localparam logic [6:0] CMD_DISPLAY  = 7'b0000001;

    typedef enum logic [2:0] {
        MODE_CTRL_WR = 3'd0,
        MODE_CTRL_RD = 3'd1,
        MODE_DATA_WR = 3'd2,
        MODE_DATA_RD = 3'd3,
        MODE_STBY_WR = 3'd4,
        MODE_STBY_RD = 3'd5,
        MODE_SCAN    = 3'd6,
        MODE_NOP     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage
`default_nettype wire

/* design/lcd_controller_bus_interface.sv */
// Top level of the monochrome LCD controller bus interface.
//
//  Channel   Direction  Transfer contents
//  s_axis    in         tdata: data[7:0], scan_row[13:8], scan_col[16:14]; tuser: mode
//  m_axis    out        tdata: read_data[7:0], contrast[13:8], opamp_one[15:14],
//                       opamp_two[17:16]
//
// Each access has an accept cycle and an execute cycle: the accept cycle computes
// the store address and issues the synchronous store read, the execute cycle
// updates the registers, writes back the (possibly masked) byte and loads the
// result register. After reset the display store is cleared one entry per cycle;
// s_axis_tready stays low while the clear runs.
// A result waiting in the output register does not block the next input
// transfer; only the execute cycle waits until the output register is free.
`default_nettype none
module lcd_controller_bus_interface
    import lcdbi_pkg::*;
#(
    parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF,
    parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
    parameter int STORE_DEPTH     = STORE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data, scan_row, scan_col, zero fill
    input  wire logic [2:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // read_data, contrast, opamp_one, opamp_two, zero fill
);

    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;
    logic [7:0] read_data;
    logic [5:0] contrast;
    logic [1:0] opamp_one;
    logic [1:0] opamp_two;

    // The controller sequences clearing, accept and execute; it owns both
    // handshakes and the output valid flag.
    lcdbi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    // The datapath holds the display store, all controller registers and
    // the result payload register.
    lcdbi_datapath #(
        .DISPLAY_ROWS    (DISPLAY_ROWS),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
        .STORE_DEPTH     (STORE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_mode      (s_axis_tuser),
        .i_data      (s_axis_tdata[7:0]),
        .i_scan_row  (s_axis_tdata[13:8]),
        .i_scan_col  (s_axis_tdata[16:14]),
        .o_read_data (read_data),
        .o_contrast  (contrast),
        .o_opamp_one (opamp_one),
        .o_opamp_two (opamp_two)
    );

    assign m_axis_tdata = {6'd0, opamp_two, opamp_one, contrast, read_data};

endmodule
`default_nettype wire

/* design/lcdbi_ctrl.sv */
// Sequencing state machine: store clearing, accept, execute and output handoff.
`default_nettype none
module lcdbi_ctrl
    import lcdbi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    s_axis_tvalid,
    output logic         s_axis_tready,
    output logic         m_axis_tvalid,
    input  wire logic    m_axis_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.clear_step = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.commit     = 1'b0;
        s_axis_tready    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result slot must be free or emptied in this cycle.
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;

endmodule
`default_nettype wire

/* design/lcdbi_datapath.sv */
// Datapath: display store, address counters, command decode and result register.
`default_nettype none
module lcdbi_datapath
    import lcdbi_pkg::*;
#(
    parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF,
    parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
    parameter int STORE_DEPTH     = STORE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_data,
    input  wire logic [5:0] i_scan_row,
    input  wire logic [2:0] i_scan_col,
    output logic [7:0]      o_read_data,
    output logic [5:0]      o_contrast,
    output logic [1:0]      o_opamp_one,
    output logic [1:0]      o_opamp_two
);

    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int COL_BYTES = DISPLAY_COLUMNS / 8;

    // Architectural registers.
    logic [5:0] r_x, n_x;
    logic [3:0] r_y, n_y;
    logic [5:0] r_z, n_z;
    logic [5:0] r_contrast, n_contrast;
    logic [1:0] r_opamp1, n_opamp1;
    logic [1:0] r_opamp2, n_opamp2;
    logic       r_up, n_up;
    logic       r_step_y, n_step_y;
    logic       r_eight, n_eight;
    logic       r_disp, n_disp;
    logic       r_stby, n_stby;
    logic [7:0] r_latch, n_latch;

    // Clearing sweep and the captured access.
    logic [AW-1:0] r_clr_addr;
    t_mode         r_mode;
    logic [7:0]    r_data;
    logic [AW-1:0] r_addr;
    logic          r_addr_ok;
    logic          r_scan_ok;
    logic [7:0]    r_rd_data;

    logic [7:0] r_mem [STORE_DEPTH];

    // Result register.
    logic [7:0] r_out_rd;
    logic [5:0] r_out_contrast;
    logic [1:0] r_out_opamp1;
    logic [1:0] r_out_opamp2;

    // Accept-side address generation.
    logic [FULL_ADDR_W-1:0] data_addr;
    logic [FULL_ADDR_W-1:0] scan_addr;
    logic [FULL_ADDR_W-1:0] sel_addr;
    logic [5:0]             scan_src;
    logic                   scan_in_range;

    // Execute-side results.
    logic [7:0] rd_value;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic       skip;

    function automatic logic [3:0] step_y(input logic [3:0] y, input logic up,
                                          input logic eight);
        logic [3:0] t;
        if (up) begin
            t = y + 4'd1;
            if (t == (eight ? Y_WRAP_8 : Y_WRAP_6)) begin
                t = 4'd0;
            end
        end else begin
            t = y - 4'd1;
            if (t == Y_UNDER) begin
                t = eight ? Y_LAST_8 : Y_LAST_6;
            end
        end
        return t;
    endfunction

    function automatic logic [5:0] step_x(input logic [5:0] x, input logic up);
        logic [5:0] t;
        if (up) begin
            t = x + 6'd1;
            if (t == X_WRAP) begin
                t = 6'd0;
            end
        end else begin
            t = x - 6'd1;
            if (t == X_UNDER) begin
                t = X_LAST;
            end
        end
        return t;
    endfunction

    // Row rotation: reduces a value below 128 modulo the row count by
    // restoring subtraction of shifted multiples, seven steps.
    function automatic logic [5:0] row_mod(input logic [6:0] v_in);
        logic [13:0] v;
        v = {7'd0, v_in};
        for (int k = 6; k >= 0; k--) begin
            if (v >= (14'(DISPLAY_ROWS) << k)) begin
                v = v - (14'(DISPLAY_ROWS) << k);
            end
        end
        return v[5:0];
    endfunction

    assign data_addr = {1'b0, r_x, 3'd0} + {6'd0, r_y};
    assign scan_src  = row_mod({1'b0, i_scan_row} + {1'b0, r_z});
    assign scan_addr = {1'b0, scan_src, i_scan_col};
    assign scan_in_range = ({1'b0, i_scan_row} < 7'(DISPLAY_ROWS)) &&
                           ({1'b0, i_scan_col} < 4'(COL_BYTES));
    assign sel_addr = (t_mode'(i_mode) == MODE_SCAN) ? scan_addr : data_addr;

    assign o_sts.clear_last = (r_clr_addr == AW'(STORE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Capture of the accepted access and the store read for it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= t_mode'(i_mode);
            r_data    <= i_data;
            r_addr    <= sel_addr[AW-1:0];
            r_addr_ok <= (32'(sel_addr) < 32'(STORE_DEPTH));
            r_scan_ok <= scan_in_range;
            r_rd_data <= r_mem[sel_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
    end

    always_comb begin
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_contrast = r_contrast;
        n_opamp1   = r_opamp1;
        n_opamp2   = r_opamp2;
        n_up       = r_up;
        n_step_y   = r_step_y;
        n_eight    = r_eight;
        n_disp     = r_disp;
        n_stby     = r_stby;
        n_latch    = r_latch;
        rd_value   = 8'd0;
        mem_we     = 1'b0;
        mem_wdata  = r_data;
        skip       = (r_x > X_LAST) || (r_y > Y_LAST_6) || (r_eight && (r_y > Y_LAST_8));

        case (r_mode)
            MODE_CTRL_WR: begin
                if (r_data[7:6] == CMD_CONTRAST) begin
                    n_contrast = r_data[5:0];
                end else if (r_data[7:6] == CMD_X_ADDR) begin
                    n_x = r_data[5:0];
                end else if (r_data[7:6] == CMD_Z_ADDR) begin
                    n_z = r_data[5:0];
                end else if (r_data[7:5] == CMD_Y_ADDR) begin
                    n_y = r_data[3:0];
                end else if (r_data[7:3] == CMD_TEST) begin
                    n_x = r_x;  // Test mode has no effect.
                end else if (r_data[7:3] == CMD_OPAMP_2) begin
                    n_opamp2 = r_data[1:0];
                end else if (r_data[7:3] == CMD_OPAMP_1) begin
                    n_opamp1 = r_data[1:0];
                end else if (r_data[7:2] == CMD_COUNTER) begin
                    n_step_y = r_data[1];
                    n_up     = r_data[0];
                end else if (r_data[7:1] == CMD_DISPLAY) begin
                    n_disp = r_data[0];
                end else begin
                    n_eight = r_data[0];
                end
            end
            MODE_CTRL_RD: begin
                rd_value = {r_stby, r_eight, r_disp, 3'd0, r_step_y, r_up};
            end
            MODE_DATA_WR: begin
                mem_we = i_cmd.commit && !skip && r_addr_ok;
                if (r_eight) begin
                    mem_wdata = r_data;
                end else if (r_y != Y_LAST_6) begin
                    mem_wdata = {r_rd_data[7:6], r_data[5:0]};
                end else begin
                    mem_wdata = {r_rd_data[7:6], r_data[5:2], r_rd_data[1:0]};
                end
                if (r_step_y) begin
                    n_y = step_y(r_y, r_up, r_eight);
                end else begin
                    n_x = step_x(r_x, r_up);
                end
            end
            MODE_DATA_RD: begin
                if (!r_stby) begin
                    rd_value = r_latch;
                    if (!r_eight && (r_y > Y_LAST_6)) begin
                        n_latch = OOR_Y_TAG | {4'h0, r_y};
                    end else if ((r_x > X_LAST) || (r_eight && (r_y > Y_LAST_8))) begin
                        n_latch = r_eight ? OOR_FILL_8 : OOR_FILL_6;
                    end else if (!r_addr_ok) begin
                        n_latch = 8'd0;
                    end else if (r_eight) begin
                        n_latch = r_rd_data;
                    end else if (r_y != Y_LAST_6) begin
                        n_latch = {2'b00, r_rd_data[5:0]};
                    end else begin
                        n_latch = {2'b00, r_rd_data[5:2], 2'b00};
                    end
                    if (r_step_y) begin
                        n_y = step_y(r_y, r_up, r_eight);
                    end else begin
                        n_x = step_x(r_x, r_up);
                    end
                end
            end
            MODE_STBY_WR: begin
                n_stby = r_data[0];
            end
            MODE_STBY_RD: begin
                rd_value = {7'd0, r_stby};
            end
            MODE_SCAN: begin
                if (r_disp && !r_stby && r_scan_ok && r_addr_ok) begin
                    rd_value = r_rd_data;
                end
            end
            default: begin
                rd_value = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_z        <= '0;
            r_contrast <= '0;
            r_opamp1   <= '0;
            r_opamp2   <= '0;
            r_up       <= 1'b1;
            r_step_y   <= 1'b1;
            r_eight    <= 1'b1;
            r_disp     <= 1'b0;
            r_stby     <= 1'b0;
            r_latch    <= '0;
        end else if (i_cmd.commit) begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_z        <= n_z;
            r_contrast <= n_contrast;
            r_opamp1   <= n_opamp1;
            r_opamp2   <= n_opamp2;
            r_up       <= n_up;
            r_step_y   <= n_step_y;
            r_eight    <= n_eight;
            r_disp     <= n_disp;
            r_stby     <= n_stby;
            r_latch    <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rd       <= rd_value;
            r_out_contrast <= n_contrast;
            r_out_opamp1   <= n_opamp1;
            r_out_opamp2   <= n_opamp2;
        end
    end

    assign o_read_data = r_out_rd;
    assign o_contrast  = r_out_contrast;
    assign o_opamp_one = r_out_opamp1;
    assign o_opamp_two = r_out_opamp2;

endmodule
`default_nettype wire

/* tb/sv/lcd_controller_bus_interface_tb.sv */
// Self-checking testbench for the LCD controller bus interface.
`timescale 1ns / 100ps

module lcd_controller_bus_interface_tb;
    import lcdbi_pkg::*;

    localparam int DISPLAY_ROWS    = DISPLAY_ROWS_DEF;
    localparam int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF;
    localparam int STORE_DEPTH     = DISPLAY_COLUMNS_DEF * 0 + STORE_DEPTH_DEF;

    // Word length command: seven zero bits followed by the 8-bit flag.
    localparam logic [6:0] CMD_WORD_LEN = 7'b0000000;

    // Number of random accesses and length of the long output hold-off.
    localparam int RANDOM_ACCESSES = 900;
    localparam int HOLD_OFF_CYCLES = 150;

    // One reply as the block packs it into m_axis_tdata.
    typedef struct {
        logic [7:0] read_data;
        logic [5:0] contrast;
        logic [1:0] opamp_one;
        logic [1:0] opamp_two;
    } t_lcd_reply;

    // The scoreboard keeps its own copy of the controller state. Every accepted
    // access is executed on that copy and the reply it must produce is queued;
    // every reply the block delivers is compared with the oldest queued one.
    class lcd_reply_scoreboard;
        logic [7:0] pixels [STORE_DEPTH];
        logic [5:0] x_addr;
        logic [3:0] y_addr;
        logic [5:0] z_off;
        logic [5:0] contrast;
        logic [1:0] opamp_one;
        logic [1:0] opamp_two;
        logic       count_up;
        logic       step_y;
        logic       eight_bit;
        logic       display_on;
        logic       standby;
        logic [7:0] read_latch;
        t_lcd_reply replies_due[$];
        int         bad_replies;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            x_addr      = '0;
            y_addr      = '0;
            z_off       = '0;
            contrast    = '0;
            opamp_one   = '0;
            opamp_two   = '0;
            count_up    = 1'b1;
            step_y      = 1'b1;
            eight_bit   = 1'b1;
            display_on  = 1'b0;
            standby     = 1'b0;
            read_latch  = '0;
            bad_replies = 0;
        endfunction

        // Advance the selected address counter after a data access. Out-of-range
        // values count on and wrap only at the regular wrap points or on overflow.
        function void step_address();
            if (step_y) begin
                y_addr = count_up ? y_addr + 4'd1 : y_addr - 4'd1;
                if (count_up && y_addr == (eight_bit ? Y_WRAP_8 : Y_WRAP_6))
                    y_addr = '0;
                if (!count_up && y_addr == Y_UNDER)
                    y_addr = eight_bit ? Y_LAST_8 : Y_LAST_6;
            end else begin
                x_addr = count_up ? x_addr + 6'd1 : x_addr - 6'd1;
                if (count_up && x_addr == X_WRAP)
                    x_addr = '0;
                if (!count_up && x_addr == X_UNDER)
                    x_addr = X_LAST;
            end
        endfunction

        function void note_access(t_mode mode, logic [7:0] d, logic [5:0] row,
                                  logic [2:0] col);
            t_lcd_reply reply;
            int         addr;
            int         src;
            logic       skip;
            logic [7:0] word;

            reply.read_data = 8'h00;
            addr = int'(x_addr) * 8 + int'(y_addr);
            case (mode)
                MODE_CTRL_WR: begin
                    if (d[7:6] == CMD_CONTRAST)      contrast   = d[5:0];
                    else if (d[7:6] == CMD_X_ADDR)   x_addr     = d[5:0];
                    else if (d[7:6] == CMD_Z_ADDR)   z_off      = d[5:0];
                    else if (d[7:5] == CMD_Y_ADDR)   y_addr     = d[3:0];
                    else if (d[7:3] == CMD_TEST)     ; // test mode has no effect
                    else if (d[7:3] == CMD_OPAMP_2)  opamp_two  = d[1:0];
                    else if (d[7:3] == CMD_OPAMP_1)  opamp_one  = d[1:0];
                    else if (d[7:2] == CMD_COUNTER) begin
                        step_y   = d[1];
                        count_up = d[0];
                    end
                    else if (d[7:1] == CMD_DISPLAY)  display_on = d[0];
                    else                             eight_bit  = d[0];
                end
                MODE_CTRL_RD: begin
                    reply.read_data = {standby, eight_bit, display_on, 3'b000,
                                       step_y, count_up};
                end
                MODE_DATA_WR: begin
                    skip = x_addr > X_LAST || y_addr > Y_LAST_6 ||
                           (eight_bit && y_addr > Y_LAST_8);
                    if (!skip && addr < STORE_DEPTH) begin
                        // Six-bit words keep the top two bits; at y = 10 only
                        // bits 5..2 are replaced.
                        if (eight_bit)
                            pixels[addr] = d;
                        else if (y_addr != Y_LAST_6)
                            pixels[addr] = (pixels[addr] & 8'hc0) | (d & 8'h3f);
                        else
                            pixels[addr] = (pixels[addr] & 8'hc3) | (d & 8'h3c);
                    end
                    step_address();
                end
                MODE_DATA_RD: begin
                    // A read hands back the old latch and refills it, unless
                    // the panel is in standby.
                    if (!standby) begin
                        reply.read_data = read_latch;
                        if (!eight_bit && y_addr > Y_LAST_6) begin
                            read_latch = 8'h20 | {4'h0, y_addr};
                        end else if (x_addr > X_LAST ||
                                     (eight_bit && y_addr > Y_LAST_8)) begin
                            read_latch = eight_bit ? OOR_FILL_8 : OOR_FILL_6;
                        end else begin
                            word = (addr < STORE_DEPTH) ? pixels[addr] : 8'h00;
                            if (eight_bit)
                                read_latch = word;
                            else if (y_addr != Y_LAST_6)
                                read_latch = word & 8'h3f;
                            else
                                read_latch = word & 8'h3c;
                        end
                        step_address();
                    end
                end
                MODE_STBY_WR: standby = d[0];
                MODE_STBY_RD: reply.read_data = {7'h00, standby};
                MODE_SCAN: begin
                    if (display_on && !standby && int'(row) < DISPLAY_ROWS &&
                        int'(col) < DISPLAY_COLUMNS / 8) begin
                        src  = (int'(row) + int'(z_off)) % DISPLAY_ROWS;
                        addr = src * 8 + int'(col);
                        if (addr < STORE_DEPTH)
                            reply.read_data = pixels[addr];
                    end
                end
                default: ;
            endcase
            reply.contrast  = contrast;
            reply.opamp_one = opamp_one;
            reply.opamp_two = opamp_two;
            replies_due.push_back(reply);
        endfunction

        function void check_reply(logic [23:0] beat);
            t_lcd_reply got;
            t_lcd_reply want;

            got.read_data = beat[7:0];
            got.contrast  = beat[13:8];
            got.opamp_one = beat[15:14];
            got.opamp_two = beat[17:16];
            if (replies_due.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("%0t: reply %h arrived with none outstanding", $realtime, beat);
                return;
            end
            want = replies_due.pop_front();
            if (got.read_data !== want.read_data || got.contrast !== want.contrast ||
                got.opamp_one !== want.opamp_one || got.opamp_two !== want.opamp_two)
            begin
                bad_replies++;
                if (bad_replies <= 10) begin
                    $display("%0t: reply mismatch: read_data exp %h got %h, contrast exp %h got %h",
                             $realtime, want.read_data, got.read_data,
                             want.contrast, got.contrast);
                    $display("    opamp_one exp %h got %h, opamp_two exp %h got %h",
                             want.opamp_one, got.opamp_one, want.opamp_two, got.opamp_two);
                end
            end
        endfunction
    endclass

    // Clock, reset and the two stream channels. Every input starts at a known
    // value; reset is held at the start and never again.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // data, scan_row, scan_col, zero fill
    logic [2:0]  s_axis_tuser  = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // read_data, contrast, opamp_one, opamp_two, zero fill

    // Idle percentages of the sender and the receiver for the current phase.
    int tx_idle_pct = 20;
    int rx_idle_pct = 50;
    int phase       = 1;
    // Set while the receiver holds tready low for the long stretch.
    logic hold_rx = 1'b0;

    lcd_reply_scoreboard sb = new();

    lcd_controller_bus_interface dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offer one access on s_axis and wait for its transfer. A random gap with
    // tvalid low may come first; without a gap tvalid simply stays high from
    // the previous transfer. The handshake is sampled right after the edge, so
    // the values seen are the ones the block saw at that edge.
    task automatic send_access(input t_mode mode, input logic [7:0] d,
                               input logic [5:0] row, input logic [2:0] col);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'h00, col, row, d};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_access(mode, d, row, col);
    endtask

    // Mostly well-formed commands, with addresses inside the valid window most
    // of the time so that data accesses actually reach the display store.
    function automatic logic [7:0] random_command();
        logic [3:0] y_top;

        y_top = sb.eight_bit ? Y_LAST_8 : Y_LAST_6;
        case ($urandom_range(11))
            0: return {CMD_CONTRAST, 6'($urandom_range(63))};
            1, 2: begin
                if ($urandom_range(7) == 0)
                    return {CMD_X_ADDR, 6'($urandom_range(63))};
                return {CMD_X_ADDR, 6'($urandom_range(int'(X_LAST)))};
            end
            3: return {CMD_Z_ADDR, 6'($urandom_range(63))};
            4, 5: begin
                if ($urandom_range(7) == 0)
                    return {CMD_Y_ADDR, 5'($urandom_range(31))};
                return {CMD_Y_ADDR, 1'($urandom_range(1)), 4'($urandom_range(int'(y_top)))};
            end
            6: return {CMD_OPAMP_1, 3'($urandom_range(7))};
            7: return {CMD_OPAMP_2, 3'($urandom_range(7))};
            8: return {CMD_COUNTER, 2'($urandom_range(3))};
            9: return {CMD_DISPLAY, 1'($urandom_range(7) != 0)};
            10: return {CMD_WORD_LEN, 1'($urandom_range(1))};
            default: begin
                if ($urandom_range(1) == 0)
                    return {CMD_TEST, 3'($urandom_range(7))};
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    // One random access, weighted toward data traffic and scan fetches.
    task automatic random_access();
        int         pick;
        logic [7:0] d;
        logic [5:0] row;
        t_mode      mode;

        pick = $urandom_range(99);
        d    = 8'($urandom_range(255));
        row  = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                        : 6'($urandom_range(DISPLAY_ROWS - 1));
        if (pick < 35) begin
            mode = MODE_DATA_WR;
        end else if (pick < 55) begin
            mode = MODE_DATA_RD;
        end else if (pick < 75) begin
            mode = MODE_CTRL_WR;
            d    = random_command();
        end else if (pick < 87) begin
            mode = MODE_SCAN;
        end else if (pick < 91) begin
            mode = MODE_CTRL_RD;
        end else if (pick < 94) begin
            // Standby is entered only now and then, so reads stay useful.
            mode = MODE_STBY_WR;
            d[0] = ($urandom_range(3) == 0);
        end else if (pick < 97) begin
            mode = MODE_STBY_RD;
        end else begin
            mode = MODE_NOP;
        end
        send_access(mode, d, row, 3'($urandom_range(7)));
    endtask

    // Receiver: check every reply transfer, then decide tready for the next
    // cycle. While the long hold-off runs, tready stays low.
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_reply(m_axis_tdata);
            if (hold_rx)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off at the start of the last phase. The sender keeps
    // offering accesses, so the output register and the pipeline fill up and
    // the block has to drop s_axis_tready.
    initial begin
        wait (phase == 3);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Stimulus: directed accesses first, then three random phases with
    // different idle patterns.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Status after reset, extreme contrast and op-amp settings, test mode.
        send_access(MODE_CTRL_RD, 8'h00, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_CONTRAST, 6'h3f}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_OPAMP_1, 3'b111}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_OPAMP_2, 3'b111}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_TEST, 3'b111}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_DISPLAY, 1'b1}, 6'd0, 3'd0);
        // Eight-bit writes: y wraps after 7, an out-of-range y writes nothing
        // but still steps.
        send_access(MODE_DATA_WR, 8'hff, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_Y_ADDR, 5'd7}, 6'd0, 3'd0);
        send_access(MODE_DATA_WR, 8'ha5, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_Y_ADDR, 5'h1f}, 6'd0, 3'd0);
        send_access(MODE_DATA_WR, 8'h3c, 6'd0, 3'd0);
        send_access(MODE_DATA_RD, 8'h00, 6'd0, 3'd0);
        // Six-bit words: masked write at y = 10, read with y beyond 10.
        send_access(MODE_CTRL_WR, {CMD_WORD_LEN, 1'b0}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_Y_ADDR, 5'd10}, 6'd0, 3'd0);
        send_access(MODE_DATA_WR, 8'hff, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_Y_ADDR, 5'd12}, 6'd0, 3'd0);
        send_access(MODE_DATA_RD, 8'h00, 6'd0, 3'd0);
        // x counting down from an out-of-range address.
        send_access(MODE_CTRL_WR, {CMD_COUNTER, 2'b00}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_X_ADDR, 6'h3f}, 6'd0, 3'd0);
        send_access(MODE_DATA_RD, 8'h00, 6'd0, 3'd0);
        // Standby blocks data reads and scan fetches.
        send_access(MODE_STBY_WR, 8'h01, 6'd0, 3'd0);
        send_access(MODE_DATA_RD, 8'h00, 6'd0, 3'd0);
        send_access(MODE_SCAN, 8'h00, 6'd0, 3'd0);
        send_access(MODE_STBY_RD, 8'h00, 6'd0, 3'd0);
        send_access(MODE_STBY_WR, 8'h00, 6'd0, 3'd0);
        // Scan with the largest z offset, an out-of-range row, unused mode.
        send_access(MODE_CTRL_WR, {CMD_Z_ADDR, 6'h3f}, 6'd0, 3'd0);
        send_access(MODE_SCAN, 8'h00, 6'd47, 3'd7);
        send_access(MODE_SCAN, 8'h00, 6'd63, 3'd0);
        send_access(MODE_NOP, 8'hff, 6'h3f, 3'd7);
        send_access(MODE_CTRL_WR, {CMD_WORD_LEN, 1'b1}, 6'd0, 3'd0);
        send_access(MODE_CTRL_WR, {CMD_COUNTER, 2'b11}, 6'd0, 3'd0);

        for (int i = 0; i < RANDOM_ACCESSES; i++) begin
            if (i == RANDOM_ACCESSES / 3) begin
                tx_idle_pct = 50;
                rx_idle_pct = 20;
                phase       = 2;
            end else if (i == 2 * RANDOM_ACCESSES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                phase       = 3;
            end
            random_access();
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding replies, then keep the clock running to show any
        // stray transfer.
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.bad_replies == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the store clear.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/lcdbi_pkg.sv
design/lcdbi_ctrl.sv
design/lcdbi_datapath.sv
design/lcd_controller_bus_interface.sv
tb/sv/lcd_controller_bus_interface_tb.sv
